### hw/rtl/linear_blend_vertex_skinning_top_defines.svh
// Assertion macros shared by the skinning block.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LBVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbvs assertion failed");

// Next-cycle implication, checked out of reset.
`define LBVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbvs assertion failed");

`endif

### hw/rtl/lbvs_pkg.sv
package lbvs_pkg;

	localparam int ELEMS = 12;
	localparam int LIMIT_FOUR = 4;
	localparam int LIMIT_EIGHT = 8;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_VERT = 2'd1;
	localparam logic [1:0] KIND_INFL = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         bone_sel;
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [16:0]        weight;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               saturated;
	} out_item_t;

	// Classified item as held in the queue between front and back.
	typedef struct packed {
		logic [1:0]         op;
		logic               bone_ok;
		logic [7:0]         bone;
		logic [3:0]         elem;
		logic signed [31:0] value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [16:0]        weight;
	} q_item_t;

	typedef struct packed {
		logic pop;
		logic out_load;
		logic idle;
	} bk_status_t;

endpackage

### hw/rtl/lbvs_ram.sv
module lbvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/lbvs_front.sv
module lbvs_front #(
	parameter int MAX_BONES = 256
) (
	input  lbvs_pkg::in_item_t in_data,
	input  logic               in_valid,
	input  logic               q_full,
	output logic               in_stall,
	output logic               push,
	output lbvs_pkg::q_item_t  entry
);

	logic bone_ok;
	logic keep;

	assign bone_ok = (32'(in_data.bone_sel) < MAX_BONES);
	assign in_stall = q_full;

	// Drop unused kinds and loads that address nothing.
	always_comb begin
		unique case (in_data.kind)
			lbvs_pkg::KIND_LOAD: keep = bone_ok && (in_data.element_index < 4'(lbvs_pkg::ELEMS));
			lbvs_pkg::KIND_VERT: keep = 1'b1;
			lbvs_pkg::KIND_INFL: keep = 1'b1;
			lbvs_pkg::KIND_NONE: keep = 1'b0;
		endcase
	end

	assign push = in_valid && !q_full && keep;

	always_comb begin
		entry.op      = in_data.kind;
		entry.bone_ok = bone_ok;
		entry.bone    = in_data.bone_sel;
		entry.elem    = in_data.element_index;
		entry.value   = in_data.element_value;
		entry.pos_x   = in_data.pos_x;
		entry.pos_y   = in_data.pos_y;
		entry.pos_z   = in_data.pos_z;
		entry.weight  = in_data.weight;
	end

endmodule

### hw/rtl/lbvs_queue.sv
module lbvs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lbvs_pkg::q_item_t wdata,
	input  logic              pop,
	output logic              full,
	output logic              valid,
	output lbvs_pkg::q_item_t rdata
);

	lbvs_pkg::q_item_t slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hw/rtl/lbvs_back.sv
module lbvs_back #(
	parameter int MAX_BONES = 256,
	localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   eight,
	input  logic                   q_valid,
	input  lbvs_pkg::q_item_t      q_data,
	output lbvs_pkg::bk_status_t   status,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lbvs_pkg::out_item_t    out_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_EMUL = 3'd3;
	localparam logic [2:0] ST_EADD = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
	localparam logic signed [66:0] SAT_LO = -67'sd2147483648;

	logic [2:0] state_q;
	logic [3:0] cnt_q;
	logic [1:0] r_q;
	logic [1:0] c_q;
	logic       bone_ok_q;
	logic [16:0] w_q;
	logic       sat_q;
	logic       out_valid_q;

	logic signed [47:0] acc_q [lbvs_pkg::ELEMS];
	logic signed [31:0] pos_q [3];
	logic signed [49:0] prod_q [lbvs_pkg::ELEMS];
	logic signed [31:0] res_q [3];
	logic signed [63:0] mh_q;
	logic signed [48:0] ml_q;
	logic signed [65:0] hi_q;
	logic signed [50:0] lo_q;
	lbvs_pkg::out_item_t out_q;

	logic [31:0] rdata [lbvs_pkg::ELEMS];
	logic        pop;
	logic        rd_en;
	logic        out_free;
	logic        out_load;
	logic [3:0]  limit;
	logic [3:0]  ai;
	logic signed [31:0] ah;
	logic signed [16:0] al;
	logic signed [66:0] res;
	logic signed [31:0] res_sat;
	logic        res_clip;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign rd_en    = pop && (q_data.op == lbvs_pkg::KIND_INFL);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign limit    = eight ? 4'(lbvs_pkg::LIMIT_EIGHT) : 4'(lbvs_pkg::LIMIT_FOUR);

	assign status.pop      = pop;
	assign status.out_load = out_load;
	assign status.idle     = (state_q == ST_IDLE);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// One bank per transform element, all read for the same bone.
	for (genvar e = 0; e < lbvs_pkg::ELEMS; e++) begin : g_bank
		lbvs_ram #(.WIDTH(32), .DEPTH(MAX_BONES)) u_ram (
			.clk   (clk),
			.we    (pop && (q_data.op == lbvs_pkg::KIND_LOAD) && (q_data.elem == 4'(e))),
			.waddr (AW'(q_data.bone)),
			.wdata (q_data.value),
			.re    (rd_en),
			.raddr (AW'(q_data.bone)),
			.rdata (rdata[e])
		);
	end

	assign ai = 4'({2'b00, r_q} * 4'd3) + {2'b00, c_q};
	assign ah = acc_q[ai][47:16];
	assign al = $signed({1'b0, acc_q[ai][15:0]});

	always_comb begin
		res = 67'(hi_q) + 67'(lo_q >>> 16) + 67'(acc_q[4'd9 + {2'b00, r_q}]);
		res_clip = 1'b0;
		res_sat  = res[31:0];
		if (res > SAT_HI) begin
			res_sat  = SAT_HI[31:0];
			res_clip = 1'b1;
		end else if (res < SAT_LO) begin
			res_sat  = SAT_LO[31:0];
			res_clip = 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					bone_ok_q <= q_data.bone_ok;
					w_q       <= q_data.weight;
				end
			end
			ST_READ: begin
				for (int i = 0; i < lbvs_pkg::ELEMS; i++) begin
					prod_q[i] <= $signed({1'b0, w_q}) * $signed(rdata[i]);
				end
			end
			ST_ACC: begin
				hi_q  <= '0;
				lo_q  <= '0;
				sat_q <= 1'b0;
			end
			ST_EMUL: begin
				mh_q <= ah * pos_q[c_q];
				ml_q <= al * pos_q[c_q];
			end
			ST_EADD: begin
				hi_q <= hi_q + 66'(mh_q);
				lo_q <= lo_q + 51'(ml_q);
			end
			ST_FIN: begin
				res_q[r_q] <= res_sat;
				sat_q      <= sat_q | res_clip;
				hi_q       <= '0;
				lo_q       <= '0;
			end
			ST_OUT: begin
				if (out_load) begin
					out_q.out_x     <= res_q[0];
					out_q.out_y     <= res_q[1];
					out_q.out_z     <= res_q[2];
					out_q.saturated <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < lbvs_pkg::ELEMS; i++) begin
				acc_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			// Raise on a new result, drop once the held one is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (q_data.op)
							lbvs_pkg::KIND_VERT: begin
								pos_q[0] <= q_data.pos_x;
								pos_q[1] <= q_data.pos_y;
								pos_q[2] <= q_data.pos_z;
								cnt_q    <= '0;
								for (int i = 0; i < lbvs_pkg::ELEMS; i++) begin
									acc_q[i] <= '0;
								end
							end
							lbvs_pkg::KIND_INFL: state_q <= ST_READ;
							lbvs_pkg::KIND_LOAD: begin
							end
							lbvs_pkg::KIND_NONE: begin
							end
						endcase
					end
				end
				ST_READ: state_q <= ST_ACC;
				ST_ACC: begin
					if (bone_ok_q) begin
						for (int i = 0; i < lbvs_pkg::ELEMS; i++) begin
							acc_q[i] <= acc_q[i] + 48'(prod_q[i] >>> 16);
						end
					end
					cnt_q <= cnt_q + 4'd1;
					r_q   <= '0;
					c_q   <= '0;
					state_q <= ((cnt_q + 4'd1) >= limit) ? ST_EMUL : ST_IDLE;
				end
				ST_EMUL: state_q <= ST_EADD;
				ST_EADD: begin
					if (c_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= ST_EMUL;
					end
				end
				ST_FIN: begin
					c_q <= '0;
					if (r_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						r_q     <= r_q + 2'd1;
						state_q <= ST_EMUL;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						cnt_q <= '0;
						for (int i = 0; i < lbvs_pkg::ELEMS; i++) begin
							acc_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/linear_blend_vertex_skinning_top.sv
// A load or vertex item is applied when the back end pops it from the queue; a non-final influence
// holds the back end through the bone bank read, 12-lane weight multiply and accumulate.
// The final influence adds 9 multiply/add pairs and 3 row finishes before its result is
// registered at the output. While idle, the back-end sequencer takes a load or vertex item per cycle;
// it takes no new item while it works through an influence or waits for a stalled output.
// Reset (arst_n low) clears control, accumulators, position and config, not the bone banks.
`include "linear_blend_vertex_skinning_top_defines.svh"

module linear_blend_vertex_skinning_top #(
	parameter int MAX_BONES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lbvs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lbvs_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic                 eight_q;
	logic                 q_full;
	logic                 q_valid;
	logic                 push;
	lbvs_pkg::q_item_t    entry;
	lbvs_pkg::q_item_t    q_head;
	lbvs_pkg::bk_status_t bk;

	// Config register: always ready; the user must write it only while the block is idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eight_q <= 1'b0;
		end else if (cfg_valid) begin
			eight_q <= cfg_data;
		end
	end

	// Front end: classify each item, drop those that do nothing.
	lbvs_front #(.MAX_BONES(MAX_BONES)) u_front (
		.in_data  (in_data),
		.in_valid (in_valid),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.entry    (entry)
	);

	// Two-entry queue decouples the front from the sequencer.
	lbvs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (bk.pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_head)
	);

	// Back end: bone banks, blend accumulators, transform sequencer, output register.
	lbvs_back #(.MAX_BONES(MAX_BONES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eight     (eight_q),
		.q_valid   (q_valid),
		.q_data    (q_head),
		.status    (bk),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`LBVS_ASSERT_NOW(a_pop_nonempty, clk, arst_n, bk.pop, q_valid)
	`LBVS_ASSERT_NOW(a_load_free, clk, arst_n, bk.out_load, !out_valid || !out_stall)
	`LBVS_ASSERT_NEXT(a_load_shows, clk, arst_n, bk.out_load, out_valid && bk.idle)

endmodule
